// ----- rtl/core/b64rds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64rds_pkg
// Shared types, codes and the Base64 character map for the record decoder.
// ----------------------------------------------------------------------------
package b64rds_pkg;

  localparam int unsigned PCNT_W      = 13;
  localparam int unsigned DOMAIN_HDR  = 108;
  localparam int unsigned KIND_IDX    = 104;
  localparam int unsigned RECORD_HDR  = 109;
  localparam int unsigned Q_AW        = 2;
  localparam int unsigned Q_DEPTH     = 1 << Q_AW;

  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  typedef enum logic [1:0] {
    KIND_DOMAIN = 2'd0,
    KIND_IPFS   = 2'd1,
    KIND_IPNS   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              is_summary;
    kind_t             record_kind;
    logic [PCNT_W-1:0] payload_count;
    logic              out_last;
  } res_t;

  // bit 6: character is in the alphabet, bits 5:0: sextet value
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      r = {1'b1, 6'(ch - CH_UPPER_A)};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      r = {1'b1, 6'(ch - CH_LOWER_A) + SX_LOWER_BASE};
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      r = {1'b1, 6'(ch - CH_DIGIT_0) + SX_DIGIT_BASE};
    end else if (ch == CH_PLUS) begin
      r = {1'b1, SX_PLUS};
    end else if (ch == CH_SLASH) begin
      r = {1'b1, SX_SLASH};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64rds_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64rds_in_if
// Character request channel: one Base64 text character per request.
// ----------------------------------------------------------------------------
interface b64rds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ----- rtl/core/b64rds_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64rds_out_if
// Result request channel: payload bytes and the end-of-string summary.
// ----------------------------------------------------------------------------
interface b64rds_out_if import b64rds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              is_summary;
  logic [1:0]        record_kind;
  logic [PCNT_W-1:0] payload_count;
  logic              out_last;

  modport source (output valid, output out_byte, output is_summary, output record_kind,
                  output payload_count, output out_last, input ready);
  modport sink   (input valid, input out_byte, input is_summary, input record_kind,
                  input payload_count, input out_last, output ready);
endinterface

// ----- rtl/core/base64_record_decode_strip.sv -----
// Results are registered in the result queue and offered from its head.
// Throughput: one character per cycle; the input is taken while the four-entry result
// queue has room for two results, and the queue drains one result per cycle while
// out_ch.ready is high. Reset (synchronous, rst_n low): decoder state and byte count
// cleared, domain mode selected, result queue emptied.
// ----------------------------------------------------------------------------
// base64_record_decode_strip
// Streaming Base64 decoder that strips the record header and reports the
// record kind and payload length at the end of each string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module base64_record_decode_strip import b64rds_pkg::*; #(
  parameter int unsigned MAX_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  b64rds_in_if.sink     in_ch,
  b64rds_out_if.source  out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

  logic                rec_mode_r;
  logic [11:0]         acc_r, acc_nxt;
  logic [2:0]          pend_r, pend_nxt;
  logic                pad_r, pad_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  kind_t               kind_r, kind_nxt;

  res_t                q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     q_wp_r, q_rp_r;
  logic [Q_AW:0]       q_cnt_r, q_cnt_nxt;

  logic                accept, pop;
  logic [6:0]          sx;
  logic [11:0]         acc_sh;
  logic [3:0]          p4;
  logic [7:0]          byte_val;
  logic                byte_emit;
  logic [11:0]         acc_upd;
  logic [2:0]          pend_upd;
  logic                pad_upd;
  logic [CNT_W-1:0]    cnt_upd, start_idx, diff;
  kind_t               kind_upd, sum_kind;
  logic [CNT_W+PCNT_W-1:0] diff_wide;
  logic [PCNT_W-1:0]   sum_cnt;
  res_t                res_byte, res_sum, res_first;
  logic                sum_emit;
  logic [1:0]          n_push;
  res_t                q_head;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (q_cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));

  assign sx       = sextet_of(in_ch.in_char);
  assign acc_sh   = {acc_r[5:0], sx[5:0]};
  assign p4       = {1'b0, pend_r} + 4'd6;
  assign byte_val = 8'(acc_sh >> p4[2:0]);
  assign start_idx = rec_mode_r ? CNT_W'(RECORD_HDR) : CNT_W'(DOMAIN_HDR);

  always_comb begin
    acc_upd   = acc_r;
    pend_upd  = pend_r;
    pad_upd   = pad_r;
    cnt_upd   = cnt_r;
    kind_upd  = kind_r;
    byte_emit = 1'b0;
    if (accept && !pad_r) begin
      if (in_ch.in_char == CH_PAD) begin
        pad_upd = 1'b1;
      end else if (sx[6]) begin
        acc_upd  = acc_sh;
        pend_upd = p4[2:0];
        if (p4[3] && cnt_r < CNT_W'(MAX_BYTES)) begin
          cnt_upd = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(KIND_IDX)) begin
            kind_upd = (byte_val != 8'h00) ? KIND_IPNS : KIND_IPFS;
          end
          byte_emit = (cnt_r >= start_idx);
        end
      end
    end
  end

  always_comb begin
    sum_kind = KIND_ERROR;
    diff     = '0;
    if (rec_mode_r) begin
      if (cnt_upd > CNT_W'(KIND_IDX)) begin
        sum_kind = (kind_upd != KIND_DOMAIN) ? kind_upd : KIND_IPFS;
        if (cnt_upd > CNT_W'(RECORD_HDR)) begin
          diff = cnt_upd - CNT_W'(RECORD_HDR);
        end
      end
    end else if (cnt_upd > CNT_W'(DOMAIN_HDR)) begin
      sum_kind = KIND_DOMAIN;
      diff     = cnt_upd - CNT_W'(DOMAIN_HDR);
    end
  end

  assign diff_wide = {{PCNT_W{1'b0}}, diff};
  assign sum_cnt   = diff_wide[PCNT_W-1:0];
  assign sum_emit  = accept && in_ch.in_last;

  assign res_byte  = '{out_byte: byte_val, is_summary: 1'b0, record_kind: KIND_DOMAIN,
                       payload_count: '0, out_last: 1'b0};
  assign res_sum   = '{out_byte: 8'h00, is_summary: 1'b1, record_kind: sum_kind,
                       payload_count: sum_cnt, out_last: 1'b1};
  assign res_first = byte_emit ? res_byte : res_sum;
  assign n_push    = {1'b0, byte_emit} + {1'b0, sum_emit};

  // end of string returns all string state to reset
  assign acc_nxt  = sum_emit ? '0 : acc_upd;
  assign pend_nxt = sum_emit ? '0 : pend_upd;
  assign pad_nxt  = sum_emit ? 1'b0 : pad_upd;
  assign cnt_nxt  = sum_emit ? '0 : cnt_upd;
  assign kind_nxt = sum_emit ? KIND_DOMAIN : kind_upd;

  assign q_cnt_nxt = q_cnt_r + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_mode_r <= 1'b0;
      acc_r      <= '0;
      pend_r     <= '0;
      pad_r      <= 1'b0;
      cnt_r      <= '0;
      kind_r     <= KIND_DOMAIN;
      q_wp_r     <= '0;
      q_rp_r     <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        rec_mode_r <= cfg_wdata;
      end
      acc_r   <= acc_nxt;
      pend_r  <= pend_nxt;
      pad_r   <= pad_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
      q_wp_r  <= q_wp_r + Q_AW'(n_push);
      q_rp_r  <= q_rp_r + Q_AW'(pop);
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[q_wp_r] <= res_first;
    end
    if (n_push == 2'd2) begin
      q_mem_r[q_wp_r + Q_AW'(1)] <= res_sum;
    end
  end

  assign q_head               = q_mem_r[q_rp_r];
  assign out_ch.valid         = (q_cnt_r != '0);
  assign out_ch.out_byte      = q_head.out_byte;
  assign out_ch.is_summary    = q_head.is_summary;
  assign out_ch.record_kind   = q_head.record_kind;
  assign out_ch.payload_count = q_head.payload_count;
  assign out_ch.out_last      = q_head.out_last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BYTES))
    else $error("byte count past saturation");

  a_pend_even: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[0] == 1'b0)
    else $error("odd pending bit count");

  a_pad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pad_r && !in_ch.in_last |=> $stable(cnt_r) && $stable(acc_r))
    else $error("decoding after padding");

  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |=> cnt_r == '0 && pend_r == '0 && !pad_r)
    else $error("string state not cleared at end of string");
`endif

endmodule

// ----- tb/b64rds_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64rds_checker
// Watches the character and result channels of the record decoder, decodes
// every accepted character on its own and compares each result request,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module b64rds_checker import b64rds_pkg::*; #(
  parameter int unsigned MAX_BYTES = 4096
) (
  input  logic  clk,
  input  logic  rst_n,
  b64rds_in_if  in_ch,
  b64rds_out_if out_ch,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  output int    fail_count,
  output int    pending
);

  logic        mode_q;
  logic [11:0] acc_q;
  logic [3:0]  held_bits_q;
  logic        pad_q;
  int unsigned byte_cnt_q;
  kind_t       marker_q;
  res_t        due_q[$];
  int          errors = 0;

  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return {1'b1, 6'(ch - CH_UPPER_A)};
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return {1'b1, 6'(ch - CH_LOWER_A + 8'd26)};
    if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) return {1'b1, 6'(ch - CH_DIGIT_0 + 8'd52)};
    if (ch == CH_PLUS) return {1'b1, 6'd62};
    if (ch == CH_SLASH) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic string fmt_result(input res_t r);
    return $sformatf("byte %02h summary %0b kind %0d count %0d last %0b",
                     r.out_byte, r.is_summary, r.record_kind, r.payload_count, r.out_last);
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic clear_string();
    acc_q       = '0;
    held_bits_q = '0;
    pad_q       = 1'b0;
    byte_cnt_q  = 0;
    marker_q    = KIND_DOMAIN;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [6:0]  sx;
    logic [4:0]  nbits;
    logic [7:0]  b;
    int unsigned first_payload;
    res_t        r;
    if (!pad_q) begin
      sx = sextet_value(ch);
      if (ch == CH_PAD) begin
        pad_q = 1'b1;
      end else if (sx[6]) begin
        nbits = held_bits_q + 5'd6;
        acc_q = {acc_q[5:0], sx[5:0]};
        if (nbits >= 5'd8) begin
          b     = 8'(acc_q >> (nbits - 5'd8));
          nbits = nbits - 5'd8;
          if (byte_cnt_q < MAX_BYTES) begin
            first_payload = mode_q ? RECORD_HDR : DOMAIN_HDR;
            if (byte_cnt_q == KIND_IDX) marker_q = (b != 8'h00) ? KIND_IPNS : KIND_IPFS;
            if (byte_cnt_q >= first_payload) begin
              r          = '0;
              r.out_byte = b;
              due_q      = {due_q, r};
            end
            byte_cnt_q++;
          end
        end
        held_bits_q = nbits[3:0];
      end
    end
    if (last) begin
      r             = '0;
      r.is_summary  = 1'b1;
      r.out_last    = 1'b1;
      r.record_kind = KIND_DOMAIN;
      if (mode_q) begin
        if (byte_cnt_q <= KIND_IDX) begin
          r.record_kind = KIND_ERROR;
        end else begin
          r.record_kind = (marker_q != KIND_DOMAIN) ? marker_q : KIND_IPFS;
          if (byte_cnt_q > RECORD_HDR) r.payload_count = PCNT_W'(byte_cnt_q - RECORD_HDR);
        end
      end else if (byte_cnt_q <= DOMAIN_HDR) begin
        r.record_kind = KIND_ERROR;
      end else begin
        r.payload_count = PCNT_W'(byte_cnt_q - DOMAIN_HDR);
      end
      due_q = {due_q, r};
      clear_string();
    end
  endtask

  task automatic check_result();
    res_t want;
    res_t got;
    got.out_byte      = out_ch.out_byte;
    got.is_summary    = out_ch.is_summary;
    got.record_kind   = kind_t'(out_ch.record_kind);
    got.payload_count = out_ch.payload_count;
    got.out_last      = out_ch.out_last;
    if (due_q.size() == 0) begin
      report({"result with nothing expected: ", fmt_result(got)});
      return;
    end
    want = due_q.pop_front();
    if (got.out_byte !== want.out_byte || got.is_summary !== want.is_summary ||
        got.record_kind !== want.record_kind || got.payload_count !== want.payload_count ||
        got.out_last !== want.out_last) begin
      report({"expected ", fmt_result(want), ", got ", fmt_result(got)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = 1'b0;
      clear_string();
      due_q.delete();
    end else begin
      if (cfg_we) mode_q = cfg_wdata;
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) decode_char(in_ch.in_char, in_ch.in_last);
    end
    pending    <= due_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for base64_record_decode_strip: encoded strings around the header
// lengths with noise, padding and junk, in both modes, a mode change within
// a string, a long result hold-off, and short random strings, with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb import b64rds_pkg::*;;

  localparam int unsigned MAX_BYTES = 4096;
  localparam int CYCLE_LIMIT        = 3_000_000;
  localparam int HOLD_OFF_CYCLES    = 300;
  localparam int RANDOM_ITEMS       = 50;
  localparam int NO_SPLIT           = -1;
  localparam int KEEP_RANDOM        = -1;
  localparam int MODE_FLIP_AT       = 60;
  localparam int HOLD_AT            = 160;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       hold_off_req = 1'b0;
  logic       calm = 1'b0;
  int         fail_count;
  int         pending;
  int         items_sent = 0;
  int         cycles = 0;
  logic [7:0] byte_q[$];
  logic [7:0] text_q[$];

  b64rds_in_if  in_ch();
  b64rds_out_if out_ch();

  base64_record_decode_strip #(.MAX_BYTES(MAX_BYTES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  b64rds_checker #(.MAX_BYTES(MAX_BYTES)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return CH_UPPER_A + 8'(v);
    if (v < 52) return CH_LOWER_A + 8'(v - 26);
    if (v < 62) return CH_DIGIT_0 + 8'(v - 52);
    return (v == 6'd62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    logic [6:0] sx;
    if ($urandom_range(7) == 0) return 8'h00;
    do begin
      c  = 8'($urandom_range(255));
      sx = sextet_of(c);
    end while (sx[6] || c == CH_PAD);
    return c;
  endfunction

  function automatic logic [7:0] raw_char();
    int r;
    r = $urandom_range(9);
    if (r < 5) return sextet_char(6'($urandom_range(63)));
    if (r == 5) return CH_PAD;
    return 8'($urandom_range(255));
  endfunction

  task automatic make_bytes(input int count, input int kind_byte, input fill_t fill);
    byte_q.delete();
    repeat (count) begin
      case (fill)
        FILL_ONES:  byte_q = {byte_q, 8'hFF};
        FILL_ZEROS: byte_q = {byte_q, 8'h00};
        default:    byte_q = {byte_q, 8'($urandom_range(255))};
      endcase
    end
    if (kind_byte != KEEP_RANDOM && count > KIND_IDX) byte_q[KIND_IDX] = 8'(kind_byte);
  endtask

  task automatic add_char(input logic [7:0] ch, input int noise_pct);
    if ($urandom_range(99) < noise_pct) text_q = {text_q, noise_char()};
    text_q = {text_q, ch};
  endtask

  // junk_tail: a pad followed by characters the block must ignore
  task automatic build_text(input int noise_pct, input bit with_pad, input bit junk_tail);
    int          i;
    int          j;
    int          n;
    logic [23:0] w;
    text_q.delete();
    for (i = 0; i < byte_q.size(); i += 3) begin
      n = byte_q.size() - i;
      if (n > 3) n = 3;
      w = {byte_q[i], (n > 1) ? byte_q[i+1] : 8'h00, (n > 2) ? byte_q[i+2] : 8'h00};
      for (j = 0; j <= n; j++) add_char(sextet_char(w[23 - 6*j -: 6]), noise_pct);
      if (with_pad) begin
        for (j = n; j < 3; j++) add_char(CH_PAD, noise_pct);
      end
    end
    if (junk_tail) begin
      text_q = {text_q, CH_PAD};
      repeat ($urandom_range(8, 1)) text_q = {text_q, raw_char()};
    end
    if (text_q.size() == 0) text_q = {text_q, noise_char()};
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= ch;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_mode(input logic value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(input int cfg_at, input logic cfg_value, input int hold_at);
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      if (i == cfg_at) write_mode(cfg_value);
      if (i == hold_at) hold_off_req <= 1'b1;
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        hold_off_req <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap(calm);
      end
    end
  end

  initial begin
    int start_items;
    in_ch.valid   <= 1'b0;
    in_ch.in_char <= 8'h00;
    in_ch.in_last <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // strings with nothing decoded
    text_q = {8'h00};
    send_text(NO_SPLIT, 1'b0, NO_SPLIT);
    text_q = {8'hFF, CH_PAD, CH_UPPER_A};
    send_text(NO_SPLIT, 1'b0, NO_SPLIT);

    // domain mode at the header length
    make_bytes(DOMAIN_HDR, KEEP_RANDOM, FILL_ZEROS);
    build_text(0, 1'b1, 1'b0);
    send_text(NO_SPLIT, 1'b0, NO_SPLIT);

    // noisy string with junk tail, switched to record mode before the kind
    // byte; result side held off during the payload
    make_bytes(140, 0, FILL_RANDOM);
    build_text(10, 1'b1, 1'b1);
    text_q = {text_q, 8'hFF};
    send_text(MODE_FLIP_AT, 1'b1, HOLD_AT);

    // record mode: short record, then a record with payload
    make_bytes(KIND_IDX + 1, 0, FILL_ONES);
    build_text(0, 1'b1, 1'b0);
    send_text(NO_SPLIT, 1'b0, NO_SPLIT);
    make_bytes(RECORD_HDR + 3, 9, FILL_RANDOM);
    build_text(5, 1'b0, 1'b0);
    send_text(NO_SPLIT, 1'b0, NO_SPLIT);

    // short random strings in random modes
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      calm <= ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0) write_mode(1'($urandom_range(1)));
      text_q.delete();
      repeat ($urandom_range(12, 1)) text_q = {text_q, raw_char()};
      send_text(NO_SPLIT, 1'b0, NO_SPLIT);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
